>>> rtl/windowed_frame_timing_statistics_assert.svh
// Assertion macros for the checker file of the frame timing statistics block.
// No dependencies; the including scope must provide i_clk and i_rst_n.
`ifndef WINDOWED_FRAME_TIMING_STATISTICS_ASSERT_SVH
`define WINDOWED_FRAME_TIMING_STATISTICS_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define WFTS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wfts assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define WFTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wfts assertion failed");

`endif

>>> rtl/wfts_pkg.sv
// Package for the windowed frame timing statistics block: control types and constants.
// No dependencies.
package wfts_pkg;

    // Reset value of the window length register, in microseconds
    localparam logic [31:0] WINDOW_RESET = 32'd2000000;

    // Bits of quotient produced by the serial divider, one per cycle
    localparam int DIV_STEPS = 64;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;    // input beat accepted this cycle
        logic div_load;  // report: snapshot and start division
        logic div_step;  // one divider iteration
        logic out_load;  // move finished report into output register
    } t_wfts_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic report;    // current input closes the window
    } t_wfts_sts;

endpackage

>>> rtl/wfts_div_lane.sv
// One lane of the restoring serial divider: 64-bit dividend over 32-bit divisor.
// Depends on wfts_pkg (DIV_STEPS).
module wfts_div_lane
    import wfts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_load,
    input  logic                 i_step,
    input  logic [DIV_STEPS-1:0] i_dividend,
    input  logic [31:0]          i_divisor,
    output logic [DIV_STEPS-1:0] o_quotient
);

    logic [DIV_STEPS-1:0] r_quot;
    logic [31:0]          r_rem;
    logic [31:0]          r_div;
    logic [32:0]          rem_sh;
    logic [32:0]          rem_sub;
    logic                 fits;

    // Shift in the next dividend bit and trial-subtract
    always_comb begin
        rem_sh  = {r_rem, r_quot[DIV_STEPS-1]};
        rem_sub = rem_sh - {1'b0, r_div};
        fits    = (rem_sh >= {1'b0, r_div});
    end

    // Quotient shifts in from the low end as the dividend leaves the top
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (i_step) begin
            r_quot <= {r_quot[DIV_STEPS-2:0], fits};
            r_rem  <= fits ? rem_sub[31:0] : rem_sh[31:0];
        end
    end

    assign o_quotient = r_quot;

endmodule

>>> rtl/wfts_datapath.sv
// Datapath of the frame timing statistics block: window register, running sums,
// peaks, counters, four divider lanes and the output register. Depends on wfts_pkg.
module wfts_datapath
    import wfts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_wfts_cmd   i_cmd,
    output t_wfts_sts   o_sts,
    input  logic        i_cfg_wr,
    input  logic [31:0] i_cfg_data,
    input  logic [47:0] i_timestamp_us,
    input  logic [31:0] i_queue_wait_us,
    input  logic [31:0] i_encode_us,
    input  logic [31:0] i_send_us,
    input  logic [23:0] i_frame_bytes,
    input  logic        i_used_fallback,
    output logic [31:0] o_frames,
    output logic [31:0] o_wait_average,
    output logic [31:0] o_wait_maximum,
    output logic [31:0] o_encode_average,
    output logic [31:0] o_encode_maximum,
    output logic [31:0] o_send_average,
    output logic [31:0] o_send_maximum,
    output logic [23:0] o_size_average,
    output logic [31:0] o_fallbacks
);

    // Configuration and window state
    logic [31:0] r_window_len;
    logic [47:0] r_start;
    logic [63:0] r_wait_sum, r_encode_sum, r_send_sum, r_size_sum;
    logic [31:0] r_wait_peak, r_encode_peak, r_send_peak;
    logic [31:0] r_count, r_fb_count;

    // Report snapshot held during division
    logic [31:0] r_snap_frames, r_snap_fb;
    logic [31:0] r_snap_wait_pk, r_snap_encode_pk, r_snap_send_pk;

    // Updated values for the current beat
    logic [47:0] start_eff;
    logic [48:0] diff;
    logic [63:0] n_wait_sum, n_encode_sum, n_send_sum, n_size_sum;
    logic [31:0] n_wait_peak, n_encode_peak, n_send_peak;
    logic [31:0] n_count, n_fb_count;

    logic [63:0] q_wait, q_encode, q_send, q_size;
    logic        zero_frames;

    // Arm, accumulate and window test
    always_comb begin
        start_eff     = (r_start == '0) ? i_timestamp_us : r_start;
        diff          = {1'b0, i_timestamp_us} - {1'b0, start_eff};
        n_wait_sum    = r_wait_sum + {32'd0, i_queue_wait_us};
        n_encode_sum  = r_encode_sum + {32'd0, i_encode_us};
        n_send_sum    = r_send_sum + {32'd0, i_send_us};
        n_size_sum    = r_size_sum + {40'd0, i_frame_bytes};
        n_count       = r_count + 32'd1;
        n_fb_count    = r_fb_count + {31'd0, i_used_fallback};
        n_wait_peak   = (i_queue_wait_us > r_wait_peak) ? i_queue_wait_us : r_wait_peak;
        n_encode_peak = (i_encode_us > r_encode_peak) ? i_encode_us : r_encode_peak;
        n_send_peak   = (i_send_us > r_send_peak) ? i_send_us : r_send_peak;
        // a timestamp behind the start gives a negative difference: no report
        o_sts.report  = !diff[48] && (diff[47:0] >= {16'd0, r_window_len});
    end

    // Window length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WINDOW_RESET;
        end else if (i_cfg_wr) begin
            r_window_len <= i_cfg_data;
        end
    end

    // Running statistics: update, or clear and restart on a report
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start       <= '0;
            r_wait_sum    <= '0;
            r_encode_sum  <= '0;
            r_send_sum    <= '0;
            r_size_sum    <= '0;
            r_wait_peak   <= '0;
            r_encode_peak <= '0;
            r_send_peak   <= '0;
            r_count       <= '0;
            r_fb_count    <= '0;
        end else if (i_cmd.accept) begin
            if (o_sts.report) begin
                r_start       <= i_timestamp_us;
                r_wait_sum    <= '0;
                r_encode_sum  <= '0;
                r_send_sum    <= '0;
                r_size_sum    <= '0;
                r_wait_peak   <= '0;
                r_encode_peak <= '0;
                r_send_peak   <= '0;
                r_count       <= '0;
                r_fb_count    <= '0;
            end else begin
                r_start       <= start_eff;
                r_wait_sum    <= n_wait_sum;
                r_encode_sum  <= n_encode_sum;
                r_send_sum    <= n_send_sum;
                r_size_sum    <= n_size_sum;
                r_wait_peak   <= n_wait_peak;
                r_encode_peak <= n_encode_peak;
                r_send_peak   <= n_send_peak;
                r_count       <= n_count;
                r_fb_count    <= n_fb_count;
            end
        end
    end

    // Snapshot of the closed window's counts and peaks
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_snap_frames    <= n_count;
            r_snap_fb        <= n_fb_count;
            r_snap_wait_pk   <= n_wait_peak;
            r_snap_encode_pk <= n_encode_peak;
            r_snap_send_pk   <= n_send_peak;
        end
    end

    // Four divider lanes sharing one iteration count
    wfts_div_lane u_div_wait (
        .i_clk(i_clk), .i_load(i_cmd.div_load), .i_step(i_cmd.div_step),
        .i_dividend(n_wait_sum), .i_divisor(n_count), .o_quotient(q_wait)
    );
    wfts_div_lane u_div_encode (
        .i_clk(i_clk), .i_load(i_cmd.div_load), .i_step(i_cmd.div_step),
        .i_dividend(n_encode_sum), .i_divisor(n_count), .o_quotient(q_encode)
    );
    wfts_div_lane u_div_send (
        .i_clk(i_clk), .i_load(i_cmd.div_load), .i_step(i_cmd.div_step),
        .i_dividend(n_send_sum), .i_divisor(n_count), .o_quotient(q_send)
    );
    wfts_div_lane u_div_size (
        .i_clk(i_clk), .i_load(i_cmd.div_load), .i_step(i_cmd.div_step),
        .i_dividend(n_size_sum), .i_divisor(n_count), .o_quotient(q_size)
    );

    // Count wrapped to zero: averages report as zero
    assign zero_frames = (r_snap_frames == '0);

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_frames         <= r_snap_frames;
            o_wait_average   <= zero_frames ? 32'd0 : q_wait[31:0];
            o_wait_maximum   <= r_snap_wait_pk;
            o_encode_average <= zero_frames ? 32'd0 : q_encode[31:0];
            o_encode_maximum <= r_snap_encode_pk;
            o_send_average   <= zero_frames ? 32'd0 : q_send[31:0];
            o_send_maximum   <= r_snap_send_pk;
            o_size_average   <= zero_frames ? 24'd0 : q_size[23:0];
            o_fallbacks      <= r_snap_fb;
        end
    end

endmodule

>>> rtl/wfts_ctrl.sv
// Controller of the frame timing statistics block: input handshake, divider
// sequencing and output valid. Depends on wfts_pkg.
module wfts_ctrl
    import wfts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    output logic      o_valid,
    input  logic      i_ready,
    input  t_wfts_sts i_sts,
    output t_wfts_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    logic [1:0]           r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        o_cmd          = '0;
        o_cmd.accept   = i_valid && o_ready;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.accept && i_sts.report) begin
                    o_cmd.div_load = 1'b1;
                    n_cnt          = '0;
                    n_state        = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                // wait for the output register to be free
                if (!r_out_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = o_cmd.out_load ? 1'b1 : (i_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> rtl/windowed_frame_timing_statistics.sv
// Top level of the windowed frame timing statistics block.
// Depends on wfts_pkg, wfts_ctrl, wfts_datapath and wfts_div_lane.
//
// Usage:
//   Input channel (i_valid/o_ready) takes one record per frame. Output channel
//   (o_valid/i_ready) gives one report beat when a record's timestamp lies at
//   least the window length past the window start. Config channel
//   (i_cfg_valid/o_cfg_ready) writes the window length, always ready; the user
//   must see it is written only while the block is idle (not enforced).
// Operation:
//   A record that closes no window only updates the statistics; o_ready stays high.
//   A record that closes a window is accepted, then divided in the restoring
//   divider (one quotient bit per cycle, four lanes in step) and moved into
//   the output register once free; o_ready is low until the report appears.
// Reset:
//   Synchronous, active low. Window length returns to 2000000 us, all sums,
//   peaks and counts clear, the window is unarmed, no report is pending.
// Stall:
//   A report waits in the output register while i_ready is low; records are
//   still taken, and the next report holds in the divider until it is free.
module windowed_frame_timing_statistics
    import wfts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [47:0] i_timestamp_us,
    input  logic [31:0] i_queue_wait_us,
    input  logic [31:0] i_encode_us,
    input  logic [31:0] i_send_us,
    input  logic [23:0] i_frame_bytes,
    input  logic        i_used_fallback,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_frames,
    output logic [31:0] o_wait_average,
    output logic [31:0] o_wait_maximum,
    output logic [31:0] o_encode_average,
    output logic [31:0] o_encode_maximum,
    output logic [31:0] o_send_average,
    output logic [31:0] o_send_maximum,
    output logic [23:0] o_size_average,
    output logic [31:0] o_fallbacks
);

    t_wfts_cmd cmd;
    t_wfts_sts sts;

    assign o_cfg_ready = 1'b1;

    wfts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    wfts_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_wr         (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_timestamp_us   (i_timestamp_us),
        .i_queue_wait_us  (i_queue_wait_us),
        .i_encode_us      (i_encode_us),
        .i_send_us        (i_send_us),
        .i_frame_bytes    (i_frame_bytes),
        .i_used_fallback  (i_used_fallback),
        .o_frames         (o_frames),
        .o_wait_average   (o_wait_average),
        .o_wait_maximum   (o_wait_maximum),
        .o_encode_average (o_encode_average),
        .o_encode_maximum (o_encode_maximum),
        .o_send_average   (o_send_average),
        .o_send_maximum   (o_send_maximum),
        .o_size_average   (o_size_average),
        .o_fallbacks      (o_fallbacks)
    );

endmodule

>>> rtl/wfts_checker.sv
// Port-level checker for the frame timing statistics block, bound to the top level.
// Depends on windowed_frame_timing_statistics_assert.svh.
`include "windowed_frame_timing_statistics_assert.svh"

module wfts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_frames,
    input logic [31:0] o_wait_average,
    input logic [31:0] o_encode_average,
    input logic [31:0] o_send_average,
    input logic [23:0] o_size_average
);

    // A stalled report beat holds
    `WFTS_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_frames))

    // Input side goes busy only right after a record beat
    `WFTS_ASSERT_NOW(a_busy_after_beat, $fell(o_ready), $past(i_valid))

    // A report appears only at the end of a busy period
    `WFTS_ASSERT_NOW(a_report_from_busy, $rose(o_valid), $past(!o_ready))

    // Wrapped frame count reports all averages as zero
    `WFTS_ASSERT_NOW(a_zero_frames, o_valid && (o_frames == 32'd0),
        (o_wait_average == 32'd0) && (o_encode_average == 32'd0) &&
        (o_send_average == 32'd0) && (o_size_average == 24'd0))

endmodule

bind windowed_frame_timing_statistics wfts_checker u_wfts_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_frames         (o_frames),
    .o_wait_average   (o_wait_average),
    .o_encode_average (o_encode_average),
    .o_send_average   (o_send_average),
    .o_size_average   (o_size_average)
);
